// ===== rtl/core/kmp_kth_occurrence_finder_assert.svh =====
// ----------------------------------------------------------------------------
// kmp_kth_occurrence_finder_assert.svh
// Assertion macros for the k-th occurrence finder.
// ----------------------------------------------------------------------------
`ifndef KMP_KTH_OCCURRENCE_FINDER_ASSERT_SVH
`define KMP_KTH_OCCURRENCE_FINDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KMPKF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define KMPKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/core/kmpkf_pkg.sv =====
// ----------------------------------------------------------------------------
// kmpkf_pkg
// Shared types and constants of the k-th occurrence finder.
// ----------------------------------------------------------------------------
package kmpkf_pkg;

    localparam int CMD_W           = 3;
    localparam int SYM_W           = 8;
    localparam int COUNT_W         = 21;
    localparam int POS_W           = 20;
    localparam int PATTERN_MAX_DEF = 1024;
    localparam int TEXT_MAX_DEF    = 1048576;
    localparam int GROUP_SIZE      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PATTERN = 3'd1,
        CMD_START   = 3'd2,
        CMD_TEXT    = 3'd3,
        CMD_END     = 3'd4
    } cmd_t;

    localparam logic STATUS_FOUND   = 1'b0;
    localparam logic STATUS_MISSING = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL,
        S_END
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic             pat_clear;
        logic             pat_append;
        logic             match_clear;
        logic             text_step;
        logic [SYM_W-1:0] symbol;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/kmpkf_cell.sv =====
// ----------------------------------------------------------------------------
// kmpkf_cell
// One pattern position: holds its byte, a tail flag and a prefix-match bit.
// ----------------------------------------------------------------------------
module kmpkf_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kmpkf_pkg::cell_ctrl_t ctrl,
    input  logic                 left_last,
    input  logic                 left_match,
    output logic                 last,
    output logic                 match,
    output logic                 hit
);

    logic [kmpkf_pkg::SYM_W-1:0] byte_reg;
    logic                        last_reg;
    logic                        last_next;
    logic                        match_reg;
    logic                        match_next;
    logic                        wr_en;

    assign wr_en = ctrl.pat_append & left_last;

    always_comb
    begin
        priority if (ctrl.pat_clear)
        begin
            last_next = 1'b0;
        end
        else if (ctrl.pat_append)
        begin
            last_next = left_last;
        end
        else
        begin
            last_next = last_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.match_clear)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.text_step)
        begin
            match_next = left_match & (ctrl.symbol == byte_reg);
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_reg <= ctrl.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            last_reg  <= last_next;
            match_reg <= match_next;
        end
    end

    assign last  = last_reg;
    assign match = match_reg;
    assign hit   = match_reg & last_reg;

endmodule

// ===== rtl/core/kmpkf_hit_tree.sv =====
// ----------------------------------------------------------------------------
// kmpkf_hit_tree
// Registered two-level OR of the cell hit flags.
// ----------------------------------------------------------------------------
module kmpkf_hit_tree #(
    parameter int CELLS = kmpkf_pkg::PATTERN_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [CELLS-1:0] hit,
    output logic             any_hit
);

    localparam int GROUP = kmpkf_pkg::GROUP_SIZE;
    localparam int NG    = (CELLS + GROUP - 1) / GROUP;

    logic [NG-1:0] grp_reg;
    logic [NG-1:0] grp_next;

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        localparam int LO = g * GROUP;
        localparam int HI = ((LO + GROUP) < CELLS) ? (LO + GROUP - 1) : (CELLS - 1);
        assign grp_next[g] = |hit[HI:LO];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else if (load)
        begin
            grp_reg <= grp_next;
        end
    end

    assign any_hit = |grp_reg;

endmodule

// ===== rtl/core/kmp_kth_occurrence_finder.sv =====
// ----------------------------------------------------------------------------
// kmp_kth_occurrence_finder
// Streaming matcher reporting the start of the k-th (overlapping) occurrence.
// ----------------------------------------------------------------------------
// Text byte: cell step (idle), grouped OR of hits (group), resolve (final);
// any result is registered at resolve. End of text: end state, result registered
// there. Other commands act in idle. A result held by out_stall holds the input.
// rst_n is asynchronous: clears pattern length, match state, counts and flags.
// Pattern bytes in the cells are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`include "kmp_kth_occurrence_finder_assert.svh"

module kmp_kth_occurrence_finder #(
    parameter int PATTERN_MAX = kmpkf_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = kmpkf_pkg::TEXT_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kmpkf_pkg::CMD_W-1:0]   cmd,
    input  logic [kmpkf_pkg::SYM_W-1:0]   symbol,
    input  logic [kmpkf_pkg::COUNT_W-1:0] k_target,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [kmpkf_pkg::POS_W-1:0]   position
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int TW = $clog2(TEXT_MAX + 1);
    localparam int DW = (TW > kmpkf_pkg::POS_W) ? TW : kmpkf_pkg::POS_W;

    kmpkf_pkg::state_t state_reg;
    kmpkf_pkg::state_t state_next;

    logic [LW-1:0]                 len_reg;
    logic [LW-1:0]                 len_next;
    logic [TW-1:0]                 text_pos_reg;
    logic [TW-1:0]                 text_pos_next;
    logic [kmpkf_pkg::COUNT_W-1:0] count_reg;
    logic [kmpkf_pkg::COUNT_W-1:0] count_next;
    logic [kmpkf_pkg::COUNT_W-1:0] count_inc;
    logic [kmpkf_pkg::COUNT_W-1:0] wanted_reg;
    logic [kmpkf_pkg::COUNT_W-1:0] wanted_next;
    logic                          reported_reg;
    logic                          reported_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          status_reg;
    logic                          status_next;
    logic [kmpkf_pkg::POS_W-1:0]   position_reg;
    logic [kmpkf_pkg::POS_W-1:0]   position_next;

    kmpkf_pkg::cell_ctrl_t         ctrl;
    logic [PATTERN_MAX-1:0]        last_w;
    logic [PATTERN_MAX-1:0]        match_w;
    logic [PATTERN_MAX-1:0]        hit_w;
    logic                          any_hit;

    logic                          full;
    logic                          text_ok;
    logic                          out_free;
    logic                          final_emit;
    logic                          final_fire;
    logic                          end_fire;
    logic                          tree_load;
    logic                          do_clear;
    logic                          do_append;
    logic                          do_start;
    logic                          do_text;
    logic                          result_load;
    logic [DW-1:0]                 diff;

    assign full       = (len_reg == LW'(PATTERN_MAX));
    assign text_ok    = ~reported_reg & (text_pos_reg < TW'(TEXT_MAX));
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign count_inc  = (count_reg == kmpkf_pkg::COUNT_MAX) ? count_reg
                                                            : count_reg + 1'b1;
    assign final_emit = any_hit & (wanted_reg != '0) & (count_inc == wanted_reg);
    assign diff       = DW'(text_pos_reg) - DW'(len_reg);

    // ---------------------------------------------------------------- cells
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic left_last;
        logic left_match;

        if (i == 0)
        begin : g_head
            assign left_last  = (len_reg == '0);
            assign left_match = 1'b1;
        end
        else
        begin : g_body
            assign left_last  = last_w[i-1];
            assign left_match = match_w[i-1];
        end

        kmpkf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_last  (left_last),
            .left_match (left_match),
            .last       (last_w[i]),
            .match      (match_w[i]),
            .hit        (hit_w[i])
        );
    end

    kmpkf_hit_tree #(
        .CELLS (PATTERN_MAX)
    ) u_hit_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (tree_load),
        .hit     (hit_w),
        .any_hit (any_hit)
    );

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmpkf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        kmpkf_pkg::CMD_TEXT:
                        begin
                            if (text_ok)
                            begin
                                state_next = kmpkf_pkg::S_GROUP;
                            end
                        end
                        kmpkf_pkg::CMD_END:
                        begin
                            if (!reported_reg)
                            begin
                                state_next = kmpkf_pkg::S_END;
                            end
                        end
                        default:
                        begin
                            state_next = kmpkf_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            kmpkf_pkg::S_GROUP:
            begin
                state_next = kmpkf_pkg::S_FINAL;
            end
            kmpkf_pkg::S_FINAL:
            begin
                if (!final_emit || out_free)
                begin
                    state_next = kmpkf_pkg::S_IDLE;
                end
            end
            kmpkf_pkg::S_END:
            begin
                if (out_free)
                begin
                    state_next = kmpkf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kmpkf_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------- outputs
    always_comb
    begin
        in_stall   = 1'b1;
        do_clear   = 1'b0;
        do_append  = 1'b0;
        do_start   = 1'b0;
        do_text    = 1'b0;
        tree_load  = 1'b0;
        final_fire = 1'b0;
        end_fire   = 1'b0;
        unique case (state_reg)
            kmpkf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (cmd)
                        kmpkf_pkg::CMD_CLEAR:   do_clear  = 1'b1;
                        kmpkf_pkg::CMD_PATTERN: do_append = 1'b1;
                        kmpkf_pkg::CMD_START:   do_start  = 1'b1;
                        kmpkf_pkg::CMD_TEXT:    do_text   = text_ok;
                        default:                do_clear  = 1'b0;
                    endcase
                end
            end
            kmpkf_pkg::S_GROUP:
            begin
                tree_load = 1'b1;
            end
            kmpkf_pkg::S_FINAL:
            begin
                final_fire = ~final_emit | out_free;
            end
            kmpkf_pkg::S_END:
            begin
                end_fire = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign ctrl.pat_clear   = do_clear;
    assign ctrl.pat_append  = do_append & ~full;
    assign ctrl.match_clear = do_clear | do_append | do_start;
    assign ctrl.text_step   = do_text;
    assign ctrl.symbol      = symbol;

    assign result_load = (final_fire & final_emit) | end_fire;

    // ------------------------------------------------------------ datapath
    always_comb
    begin
        len_next       = len_reg;
        text_pos_next  = text_pos_reg;
        count_next     = count_reg;
        wanted_next    = wanted_reg;
        reported_next  = reported_reg;
        status_next    = status_reg;
        position_next  = position_reg;
        out_valid_next = out_valid_reg & out_stall;

        if (do_clear)
        begin
            len_next = '0;
        end
        if (ctrl.pat_append)
        begin
            len_next = len_reg + 1'b1;
        end
        if (do_start)
        begin
            text_pos_next = '0;
            count_next    = '0;
            wanted_next   = k_target;
            reported_next = 1'b0;
        end
        if (do_text)
        begin
            text_pos_next = text_pos_reg + 1'b1;
        end
        if (final_fire && any_hit)
        begin
            count_next = count_inc;
        end
        if (result_load)
        begin
            reported_next  = 1'b1;
            out_valid_next = 1'b1;
            status_next    = end_fire ? kmpkf_pkg::STATUS_MISSING
                                      : kmpkf_pkg::STATUS_FOUND;
            position_next  = end_fire ? '0 : diff[kmpkf_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmpkf_pkg::S_IDLE;
            len_reg       <= '0;
            text_pos_reg  <= '0;
            count_reg     <= '0;
            wanted_reg    <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            text_pos_reg  <= text_pos_next;
            count_reg     <= count_next;
            wanted_reg    <= wanted_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;

    // ---------------------------------------------------------- assertions
    `KMPKF_ASSERT_NOW(a_tail_onehot, 1'b1, $onehot0(last_w))
    `KMPKF_ASSERT_NOW(a_count_below, (wanted_reg != '0) && !reported_reg, count_reg < wanted_reg)
    `KMPKF_ASSERT_NOW(a_load_once, result_load, !reported_reg)
    `KMPKF_ASSERT_NEXT(a_load_marks, result_load, reported_reg && out_valid)

endmodule
